// ===== hw/rtl/grmf_pkg.sv =====
`timescale 1ns / 1ps

package grmf_pkg;

  // Window depth of the running median (legal range 1 to 15).
  localparam int WINDOW = 5;

  localparam int SAMPLE_W = 24;
  localparam int GATE_W   = 23;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Configuration port.
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_GATE = 1'b0;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(500000);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WINDOW-1:0][SAMPLE_W-1:0] win_t;

  typedef struct packed {
    logic    accepted;
    sample_t median;
  } res_t;

endpackage

// ===== hw/rtl/gated_running_median_filter_top.sv =====
`timescale 1ns / 1ps

// Gated running median filter for signed distance samples in millimetres.
// Items come in on the s_t* stream; each carries one 24-bit two's complement
// sample. Every input item yields exactly one result item on the m_t* stream:
// m_tuser says whether the sample passed the jump gate, and m_tdata holds the
// median of the last accepted samples (zero when the sample was rejected).
// A sample is rejected when its distance from the last accepted sample is
// strictly larger than gate_mm; the first sample after reset always passes.
// gate_mm is written through the APB port at byte address 0; the user must
// change it only while no item is in flight, as the block does not enforce it.
// An item accepted from the s_t* stream is held in the input register, and its
// result is then loaded into the output register, which drives m_tvalid.
// Throughput is one item per cycle while the receiver does not stall; gate
// check, window update and the five-entry rank select all sit between those
// two registers, and the state update for one item is in place before the
// next one reaches the gate.
// When the receiver stalls, the result waits in the output register and the
// input register still takes one more item; s_tready drops only once both
// are full. Reset empties the window, forgets the last sample, clears both
// registers' valid flags and sets gate_mm back to 500000 mm.

module gated_running_median_filter_top (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // [23:0] sample_mm
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // [23:0] median_mm
  output logic [0:0]                    m_tuser,   // [0] accepted
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [grmf_pkg::APB_DW-1:0]   pwdata,
  output logic [grmf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import grmf_pkg::*;

  logic [GATE_W-1:0] gate_mm;
  logic              wr_en;
  res_t              res;

  // Registers sit on 4-byte boundaries; the low address bits are ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_mm <= GATE_RESET;
    end else if (wr_en && paddr[2] == REG_GATE) begin
      gate_mm <= pwdata[GATE_W-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GATE: prdata = APB_DW'(gate_mm);
      default:  prdata = '0;
    endcase
  end

  grmf_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .gate_mm   (gate_mm),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata    = res.median;
  assign m_tuser[0] = res.accepted;

endmodule

// ===== hw/rtl/grmf_median.sv =====
`timescale 1ns / 1ps

module grmf_median (
  input  grmf_pkg::win_t                 win,
  input  logic [grmf_pkg::CNT_W-1:0]     cnt,
  output grmf_pkg::sample_t              median
);
  import grmf_pkg::*;

  logic [CNT_W-1:0] pos [WINDOW];
  logic [WINDOW-1:0] used;
  logic [CNT_W-1:0] mid;

  // Each entry's place in a stable ascending order is the number of filled
  // entries that sort ahead of it; ties are broken by slot index.
  always_comb begin
    mid = cnt >> 1;
    for (int i = 0; i < WINDOW; i++) begin
      used[i] = CNT_W'(i) < cnt;
    end
    for (int i = 0; i < WINDOW; i++) begin
      pos[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i && used[j]) begin
          if ($signed(win[j]) < $signed(win[i]) ||
              (win[j] == win[i] && j < i)) begin
            pos[i] = pos[i] + CNT_W'(1);
          end
        end
      end
    end
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (used[i] && pos[i] == mid) begin
        median = win[i];
      end
    end
  end

endmodule

// ===== hw/rtl/grmf_filter.sv =====
`timescale 1ns / 1ps

module grmf_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [grmf_pkg::GATE_W-1:0]   gate_mm,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  grmf_pkg::sample_t             in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output grmf_pkg::res_t                out_res
);
  import grmf_pkg::*;

  // Input register.
  logic    stg_valid;
  sample_t stg_sample;
  logic    adv;

  // Filter state.
  sample_t           last_sample;
  logic              have_last;
  win_t              win;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  cnt;

  win_t               win_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [CNT_W-1:0]   cnt_next;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]  abs_diff;
  logic               reject;
  sample_t            median;

  assign adv      = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (adv) begin
      stg_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      stg_sample <= in_sample;
    end
  end

  // Gate: full-precision difference, so it never wraps.
  always_comb begin
    diff     = (SAMPLE_W + 1)'(stg_sample) - (SAMPLE_W + 1)'(last_sample);
    abs_diff = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : (SAMPLE_W + 1)'(diff);
    reject   = have_last && (abs_diff > (SAMPLE_W + 1)'(gate_mm));
  end

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_next[i] = (SLOT_W'(i) == slot) ? stg_sample : win[i];
    end
    slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
    cnt_next  = (cnt == CNT_W'(WINDOW)) ? cnt : cnt + CNT_W'(1);
  end

  grmf_median u_median (
    .win    (win_next),
    .cnt    (cnt_next),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
      have_last   <= 1'b0;
      slot        <= '0;
      cnt         <= '0;
    end else if (adv && !reject) begin
      last_sample <= stg_sample;
      have_last   <= 1'b1;
      slot        <= slot_next;
      cnt         <= cnt_next;
    end
    if (adv && !reject) begin
      win <= win_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_res.accepted <= !reject;
      out_res.median   <= reject ? '0 : median;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW))
    else $error("fill count beyond window depth");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW - 1))
    else $error("write slot beyond window depth");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.accepted |-> out_res.median == '0)
    else $error("rejected item carries a nonzero median");

  a_last_update: assert property (@(posedge clk) disable iff (rst)
    adv && !reject |=> have_last && last_sample == $past(stg_sample))
    else $error("accepted sample not kept as last sample");

  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(WINDOW) |-> CNT_W'(slot) == cnt)
    else $error("write slot out of step with fill count");
`endif

endmodule
